// ===== hw/rtl/svf_pkg.sv =====
// Shared types, constants and codes for the spring vector follower.
package svf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int MB_W           = 33;

  localparam logic [11:0] DT_MAX     = 12'd2185;
  localparam logic [5:0]  DAMP_K     = 6'd35;
  localparam logic [63:0] TQ_NUM     = 64'd4480 << 16;
  localparam logic [30:0] MS_RESET   = 31'd655360;
  localparam logic [30:0] K_SAT      = 31'h7FFF_FFFF;
  localparam logic        REG_MAX_SPEED = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_T,
    S_MUL_K,
    S_MUL_DK,
    S_MUL_V35,
    S_MUL_ADT,
    S_MUL_NV2,
    S_MUL_MS2,
    S_SQRT,
    S_MUL_NVMS,
    S_DIV_M,
    S_CHECK,
    S_MUL_NVDT,
    S_MUL_ED,
    S_FINISH
  } state_t;

  typedef enum logic {
    IT_DIV,
    IT_SQRT
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_req_t;

  typedef struct packed {
    logic signed [31:0] pos_now_x;
    logic signed [31:0] pos_now_y;
    logic signed [31:0] pos_now_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic [15:0]        frame_time;
    logic [15:0]        damping_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic               snapped;
  } out_item_t;

endpackage

// ===== hw/rtl/svf_mul.sv =====
// Two-pass shared multiplier: A_W bits by 33 bits, one 17-bit slice of b per cycle.
module svf_mul import svf_pkg::*; #(
  parameter int A_W = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [A_W-1:0]        a,
  input  logic [MB_W-1:0]       b,
  output logic                  done,
  output logic [A_W+MB_W-1:0]   f
);

  logic                    busy_r;
  logic                    done_r;
  logic [A_W+16:0]         lo_r;
  logic [A_W+MB_W-1:0]     f_r;
  logic [16:0]             bsel;
  logic [A_W+16:0]         prod;

  assign bsel = busy_r ? b[32:16] : {1'b0, b[15:0]};
  assign prod = (A_W+17)'(a) * (A_W+17)'(bsel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lo_r <= prod;
    end
    if (busy_r) begin
      f_r <= (A_W+MB_W)'(lo_r) + {prod, 16'b0};
    end
  end

  assign done = done_r;
  assign f    = f_r;

endmodule

// ===== hw/rtl/svf_iter.sv =====
// Bit-serial divider and square root sharing one 32-step sequencer.
module svf_iter import svf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  iter_req_t   req,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] res
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  iter_op_t    op_r;
  logic [63:0] x_r;
  logic [32:0] rem_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [31:0] den_r;

  logic [32:0] sh;
  logic        ge;
  logic [63:0] trial;
  logic        sq_ge;

  assign sh    = {rem_r[31:0], x_r[63]};
  assign ge    = sh >= {1'b0, den_r};
  assign trial = res_r + bit_r;
  assign sq_ge = x_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      den_r <= den;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
      if (req.op == IT_DIV) begin
        rem_r <= {1'b0, num[63:32]};
        x_r   <= {num[31:0], 32'b0};
      end else begin
        rem_r <= '0;
        x_r   <= num;
      end
    end else if (busy_r) begin
      case (op_r)
        IT_DIV: begin
          rem_r <= ge ? (sh - {1'b0, den_r}) : sh;
          res_r <= {res_r[62:0], ge};
          x_r   <= {x_r[62:0], 1'b0};
        end
        IT_SQRT: begin
          if (sq_ge) begin
            x_r   <= x_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
        default: begin
          res_r <= res_r;
        end
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r[31:0];

endmodule

// ===== hw/rtl/spring_vector_follower.sv =====
// Top level: damped 3-D spring follower with a shared multiplier and divide/sqrt unit.
// Work per item: a divide for the spring constant and the multiplier passes; a slow snap
//   skips the position and overshoot passes, and the speed cap adds one square root
//   and three divides.
// Flow: input stalls while an item is in work, so items are taken one at a time.
// Reset: velocity cleared, max_speed = 10.0, no result pending.
module spring_vector_follower import svf_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MA    = (DATA_WIDTH + 1 > 48) ? DATA_WIDTH + 1 : 48;
  localparam int FW    = MA + MB_W;
  localparam int EW    = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 1;
  localparam int SW    = ((DATA_WIDTH > 33) ? DATA_WIDTH : 33) + 1;
  localparam int OW    = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam int DOT_W = FW + 3;

  localparam logic signed [SW-1:0] POS_HI = $signed({{(SW-DATA_WIDTH+1){1'b0}},
                                                     {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [SW-1:0] POS_LO = ~POS_HI;
  localparam logic signed [44:0]   VEL_HI = 45'sh0_7FFF_FFFF;
  localparam logic signed [44:0]   VEL_LO = ~VEL_HI;

  state_t state_r, state_nxt;

  logic [30:0]                  ms_r;
  logic signed [31:0]           pos_r [3];
  logic signed [31:0]           tgt_r [3];
  logic signed [31:0]           vel_r [3];
  logic signed [31:0]           nv_r  [3];
  logic signed [DATA_WIDTH-1:0] np_r  [3];
  logic [11:0]                  dt_r;
  logic [15:0]                  rate_r;
  logic [31:0]                  tq_r;
  logic [30:0]                  k_r;
  logic signed [48:0]           a1_r;
  logic signed [48:0]           acc_r;
  logic [63:0]                  lsq_r;
  logic [63:0]                  num_r;
  logic [31:0]                  len_r;
  logic signed [DOT_W-1:0]      dot_r;
  logic [1:0]                   ax_r;
  logic                         cap_r;
  logic                         snap_r;
  logic                         issued_r;
  logic                         out_valid_r;
  out_item_t                    out_data_r;

  logic                in_acc;
  logic                mul_start;
  logic                mul_done;
  logic [MA-1:0]       mul_a;
  logic [MB_W-1:0]     mul_b;
  logic [FW-1:0]       mul_f;
  iter_req_t           it_req;
  logic [63:0]         it_num;
  logic [31:0]         it_den;
  logic                it_done;
  logic [31:0]         it_res;
  logic                unit_done;
  logic                is_mul;
  logic                is_iter;

  logic signed [32:0]  d_s;
  logic [32:0]         d_mag;
  logic [31:0]         v_mag;
  logic [31:0]         nv_mag;
  logic [48:0]         acc_mag;
  logic signed [EW-1:0] e_s;
  logic [EW-1:0]       e_mag;
  logic signed [48:0]  dk_val;
  logic signed [48:0]  v35_val;
  logic signed [44:0]  dv_val;
  logic signed [44:0]  vsum;
  logic signed [31:0]  vsat;
  logic signed [SW-1:0] dp_val;
  logic signed [SW-1:0] psum;
  logic signed [SW-1:0] psat;
  logic signed [DOT_W-1:0] fx;
  logic signed [DOT_W-1:0] dot_add;
  logic                out_free;
  logic                snap_w;
  logic signed [OW-1:0] npx [3];

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign snap_w   = snap_r || dot_r[DOT_W-1];

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_SPEED) ? {1'b0, ms_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r <= MS_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_SPEED)) begin
      ms_r <= pwdata[30:0];
    end
  end

  // Per-axis operands
  always_comb begin
    d_s     = 33'(tgt_r[ax_r]) - 33'(pos_r[ax_r]);
    d_mag   = d_s[32] ? 33'(-d_s) : 33'(d_s);
    v_mag   = vel_r[ax_r][31] ? 32'(-vel_r[ax_r]) : 32'(vel_r[ax_r]);
    nv_mag  = nv_r[ax_r][31] ? 32'(-nv_r[ax_r]) : 32'(nv_r[ax_r]);
    acc_mag = acc_r[48] ? 49'(-acc_r) : 49'(acc_r);
    e_s     = EW'(tgt_r[ax_r]) - EW'(np_r[ax_r]);
    e_mag   = e_s[EW-1] ? EW'(-e_s) : EW'(e_s);

    dk_val  = d_s[32] ? -$signed({2'b0, mul_f[62:16]}) : $signed({2'b0, mul_f[62:16]});
    v35_val = vel_r[ax_r][31] ? -$signed({11'b0, mul_f[37:0]})
                              : $signed({11'b0, mul_f[37:0]});
    dv_val  = acc_r[48] ? -$signed({1'b0, mul_f[59:16]}) : $signed({1'b0, mul_f[59:16]});
    vsum    = 45'(vel_r[ax_r]) + dv_val;
    if (vsum > VEL_HI) begin
      vsat = 32'sh7FFF_FFFF;
    end else if (vsum < VEL_LO) begin
      vsat = -32'sh7FFF_FFFF - 32'sd1;
    end else begin
      vsat = 32'(vsum);
    end

    dp_val  = nv_r[ax_r][31] ? -$signed(SW'({1'b0, mul_f[43:16]}))
                             : $signed(SW'({1'b0, mul_f[43:16]}));
    psum    = SW'(pos_r[ax_r]) + dp_val;
    if (psum > POS_HI) begin
      psat = POS_HI;
    end else if (psum < POS_LO) begin
      psat = POS_LO;
    end else begin
      psat = psum;
    end

    fx      = $signed(DOT_W'(mul_f));
    dot_add = (e_s[EW-1] != d_s[32]) ? -fx : fx;
  end

  // Unit control
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    it_num  = '0;
    it_den  = '0;
    is_mul  = 1'b0;
    is_iter = 1'b0;
    it_req.op = IT_DIV;
    case (state_r)
      S_DIV_T: begin
        is_iter = 1'b1;
        it_num  = TQ_NUM;
        it_den  = 32'(rate_r);
      end
      S_SQRT: begin
        is_iter   = 1'b1;
        it_req.op = IT_SQRT;
        it_num    = lsq_r;
      end
      S_DIV_M: begin
        is_iter = 1'b1;
        it_num  = num_r;
        it_den  = len_r;
      end
      S_MUL_K: begin
        is_mul = 1'b1;
        mul_a  = MA'(tq_r);
        mul_b  = MB_W'(tq_r);
      end
      S_MUL_DK: begin
        is_mul = 1'b1;
        mul_a  = MA'(d_mag);
        mul_b  = MB_W'(k_r);
      end
      S_MUL_V35: begin
        is_mul = 1'b1;
        mul_a  = MA'(v_mag);
        mul_b  = MB_W'(DAMP_K);
      end
      S_MUL_ADT: begin
        is_mul = 1'b1;
        mul_a  = MA'(acc_mag);
        mul_b  = MB_W'(dt_r);
      end
      S_MUL_NV2: begin
        is_mul = 1'b1;
        mul_a  = MA'(nv_mag);
        mul_b  = MB_W'(nv_mag);
      end
      S_MUL_MS2: begin
        is_mul = 1'b1;
        mul_a  = MA'(ms_r);
        mul_b  = MB_W'(ms_r);
      end
      S_MUL_NVMS: begin
        is_mul = 1'b1;
        mul_a  = MA'(nv_mag);
        mul_b  = MB_W'(ms_r);
      end
      S_MUL_NVDT: begin
        is_mul = 1'b1;
        mul_a  = MA'(nv_mag);
        mul_b  = MB_W'(dt_r);
      end
      S_MUL_ED: begin
        is_mul = 1'b1;
        mul_a  = MA'(e_mag);
        mul_b  = d_mag;
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
    mul_start    = is_mul && !issued_r;
    it_req.start = is_iter && !issued_r;
    unit_done    = (is_mul && mul_done) || (is_iter && it_done);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_acc) state_nxt = S_DIV_T;
      S_DIV_T:    if (it_done) state_nxt = S_MUL_K;
      S_MUL_K:    if (mul_done) state_nxt = S_MUL_DK;
      S_MUL_DK:   if (mul_done) state_nxt = S_MUL_V35;
      S_MUL_V35:  if (mul_done) state_nxt = S_MUL_ADT;
      S_MUL_ADT:  if (mul_done) state_nxt = S_MUL_NV2;
      S_MUL_NV2: begin
        if (mul_done) begin
          if (ax_r == 2'd2) begin
            state_nxt = cap_r ? S_CHECK : S_MUL_MS2;
          end else begin
            state_nxt = cap_r ? S_MUL_NVMS : S_MUL_DK;
          end
        end
      end
      S_MUL_MS2: begin
        if (mul_done) begin
          state_nxt = (lsq_r > mul_f[63:0]) ? S_SQRT : S_CHECK;
        end
      end
      S_SQRT:     if (it_done) state_nxt = S_MUL_NVMS;
      S_MUL_NVMS: if (mul_done) state_nxt = S_DIV_M;
      S_DIV_M:    if (it_done) state_nxt = S_MUL_NV2;
      S_CHECK:    state_nxt = (lsq_r[63:32] == 32'd0) ? S_FINISH : S_MUL_NVDT;
      S_MUL_NVDT: if (mul_done) state_nxt = S_MUL_ED;
      S_MUL_ED: begin
        if (mul_done) state_nxt = (ax_r == 2'd2) ? S_FINISH : S_MUL_NVDT;
      end
      S_FINISH:   if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vel_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (mul_start || it_req.start) begin
        issued_r <= 1'b1;
      end else if (unit_done) begin
        issued_r <= 1'b0;
      end
      if (state_r == S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          vel_r[i] <= snap_w ? 32'sd0 : nv_r[i];
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pos_r[0] <= in_data.pos_now_x;
          pos_r[1] <= in_data.pos_now_y;
          pos_r[2] <= in_data.pos_now_z;
          tgt_r[0] <= in_data.target_x;
          tgt_r[1] <= in_data.target_y;
          tgt_r[2] <= in_data.target_z;
          dt_r     <= (in_data.frame_time > 16'(DT_MAX)) ? DT_MAX
                                                         : in_data.frame_time[11:0];
          rate_r   <= (in_data.damping_rate == 16'd0) ? 16'd1 : in_data.damping_rate;
          lsq_r    <= '0;
          dot_r    <= '0;
          cap_r    <= 1'b0;
          snap_r   <= 1'b0;
          ax_r     <= 2'd0;
        end
      end
      S_DIV_T: begin
        if (it_done) tq_r <= it_res;
      end
      S_MUL_K: begin
        if (mul_done) k_r <= (|mul_f[FW-1:47]) ? K_SAT : mul_f[46:16];
      end
      S_MUL_DK: begin
        if (mul_done) a1_r <= dk_val;
      end
      S_MUL_V35: begin
        if (mul_done) acc_r <= a1_r - v35_val;
      end
      S_MUL_ADT: begin
        if (mul_done) nv_r[ax_r] <= vsat;
      end
      S_MUL_NV2: begin
        if (mul_done) begin
          lsq_r <= lsq_r + mul_f[63:0];
          ax_r  <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        end
      end
      S_SQRT: begin
        if (it_done) begin
          len_r <= it_res;
          lsq_r <= '0;
          cap_r <= 1'b1;
          ax_r  <= 2'd0;
        end
      end
      S_MUL_NVMS: begin
        if (mul_done) num_r <= mul_f[63:0];
      end
      S_DIV_M: begin
        if (it_done) nv_r[ax_r] <= nv_r[ax_r][31] ? -$signed(it_res) : $signed(it_res);
      end
      S_CHECK: begin
        if (lsq_r[63:32] == 32'd0) snap_r <= 1'b1;
        ax_r <= 2'd0;
      end
      S_MUL_NVDT: begin
        if (mul_done) np_r[ax_r] <= DATA_WIDTH'(psat);
      end
      S_MUL_ED: begin
        if (mul_done) begin
          dot_r <= dot_r + dot_add;
          ax_r  <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_data_r.new_x   <= snap_w ? tgt_r[0] : npx[0][31:0];
          out_data_r.new_y   <= snap_w ? tgt_r[1] : npx[1][31:0];
          out_data_r.new_z   <= snap_w ? tgt_r[2] : npx[2][31:0];
          out_data_r.snapped <= snap_w;
        end
      end
      default: begin
        ax_r <= ax_r;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      npx[i] = OW'(np_r[i]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  svf_mul #(
    .A_W (MA)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .f     (mul_f)
  );

  svf_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (it_req),
    .num   (it_num),
    .den   (it_den),
    .done  (it_done),
    .res   (it_res)
  );

endmodule

// ===== dv/spring_vector_follower_test.sv =====
// Testbench for spring_vector_follower: queued random and directed items against a predictor.
module spring_vector_follower_test;
  import svf_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  in_item_t  pending_items[$];
  out_item_t expected_positions[$];
  longint    velocity_q[3];
  longint unsigned speed_limit;
  int        mismatches = 0;
  bit        calm = 1'b0;
  int        hold_req = 0;
  int        hold_seen = 0;
  int        hold_cnt = 0;
  logic signed [31:0] trail_pos[3];
  logic signed [31:0] trail_tgt[3];

  spring_vector_follower dut (.*);

  always #6 clk = ~clk;

  function automatic longint scale_q(longint a, longint unsigned b);
    logic [127:0] m;
    logic [127:0] p;
    m = 128'((a < 0) ? -a : a);
    p = (m * b) >> 16;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return -64'sh8000_0000;
    return x;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res;
    longint unsigned c;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if (c * c <= x) res = c;
    end
    return res;
  endfunction

  function automatic out_item_t follow_step(in_item_t it);
    longint p[3], t[3], d[3], nv[3], np[3];
    longint unsigned dt, r, tq, k, lsq, len, m;
    logic signed [127:0] dot, es, ds;
    bit snap;
    out_item_t o;
    p[0] = longint'(it.pos_now_x); p[1] = longint'(it.pos_now_y);
    p[2] = longint'(it.pos_now_z);
    t[0] = longint'(it.target_x);  t[1] = longint'(it.target_y);
    t[2] = longint'(it.target_z);
    dt = 64'(it.frame_time);
    if (dt > 2185) dt = 2185;
    r = 64'(it.damping_rate);
    if (r == 0) r = 1;
    tq = (64'd4480 << 16) / r;
    k = (tq * tq) >> 16;
    if (k > 64'h7FFF_FFFF) k = 64'h7FFF_FFFF;
    lsq = 0;
    snap = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d[i] = t[i] - p[i];
      nv[i] = clamp32(velocity_q[i] + scale_q(scale_q(d[i], k) - 35 * velocity_q[i], dt));
      m = (nv[i] < 0) ? -nv[i] : nv[i];
      lsq += m * m;
    end
    if (lsq > speed_limit * speed_limit) begin
      len = root64(lsq);
      lsq = 0;
      for (int i = 0; i < 3; i++) begin
        m = (nv[i] < 0) ? -nv[i] : nv[i];
        m = m * speed_limit / len;
        nv[i] = (nv[i] < 0) ? -longint'(m) : longint'(m);
        lsq += m * m;
      end
    end
    if (lsq < (64'd1 << 32)) begin
      snap = 1'b1;
    end else begin
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        np[i] = clamp32(p[i] + scale_q(nv[i], dt));
        es = 128'(t[i] - np[i]);
        ds = 128'(d[i]);
        dot += es * ds;
      end
      snap = dot < 0;
    end
    for (int i = 0; i < 3; i++) begin
      if (snap) begin
        np[i] = t[i];
        velocity_q[i] = 0;
      end else begin
        velocity_q[i] = nv[i];
      end
    end
    o.new_x = np[0][31:0];
    o.new_y = np[1][31:0];
    o.new_z = np[2][31:0];
    o.snapped = snap;
    return o;
  endfunction

  task automatic queue_item(in_item_t it);
    out_item_t o;
    o = follow_step(it);
    pending_items.push_back(it);
    expected_positions.push_back(o);
    trail_pos[0] = o.new_x; trail_pos[1] = o.new_y; trail_pos[2] = o.new_z;
  endtask

  task automatic write_max_speed(logic [30:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {2'b00, REG_MAX_SPEED} << 2; pwdata <= {1'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    speed_limit = 64'(v);
  endtask

  task automatic drain;
    while (pending_items.size() != 0 || expected_positions.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic signed [31:0] near_coord();
    return $signed($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
  endfunction

  function automatic in_item_t make_item();
    in_item_t it;
    int mode;
    mode = $urandom_range(99);
    if (mode < 70) begin
      if ($urandom_range(9) == 0)
        for (int i = 0; i < 3; i++) trail_tgt[i] = near_coord();
      it.pos_now_x = trail_pos[0]; it.pos_now_y = trail_pos[1]; it.pos_now_z = trail_pos[2];
      it.target_x = trail_tgt[0]; it.target_y = trail_tgt[1]; it.target_z = trail_tgt[2];
      it.frame_time = 16'($urandom_range(0, 2600));
      it.damping_rate = 16'($urandom_range(1, 1024));
    end else if (mode < 85) begin
      it.pos_now_x = $urandom(); it.pos_now_y = $urandom(); it.pos_now_z = $urandom();
      it.target_x = $urandom(); it.target_y = $urandom(); it.target_z = $urandom();
      it.frame_time = 16'($urandom());
      it.damping_rate = 16'($urandom());
    end else begin
      it.pos_now_x = near_coord(); it.pos_now_y = near_coord(); it.pos_now_z = near_coord();
      if (mode < 90) begin
        it.target_x = it.pos_now_x; it.target_y = it.pos_now_y; it.target_z = it.pos_now_z;
      end else begin
        it.target_x = near_coord(); it.target_y = near_coord(); it.target_z = near_coord();
      end
      it.frame_time = 16'($urandom());
      it.damping_rate = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom());
    end
    return it;
  endfunction

  task automatic directed_items;
    in_item_t it;
    logic signed [31:0] ext[4];
    ext[0] = 32'sh7FFF_FFFF; ext[1] = -32'sh8000_0000; ext[2] = 0; ext[3] = 32'sh0001_0000;
    for (int j = 0; j < 16; j++) begin
      it.pos_now_x = ext[j % 4]; it.pos_now_y = ext[(j + 1) % 4]; it.pos_now_z = ext[(j / 4) % 4];
      it.target_x = ext[(j + 1) % 4]; it.target_y = ext[j % 4]; it.target_z = ext[(j + 2) % 4];
      it.frame_time = (j % 3 == 0) ? 16'd0 : (j % 3 == 1) ? 16'hFFFF : 16'd2185;
      it.damping_rate = (j % 4 == 0) ? 16'd0 : (j % 4 == 1) ? 16'hFFFF : 16'd256;
      queue_item(it);
    end
    // zero distance, slow approach, overshoot
    it = '0; it.frame_time = 16'd1000; it.damping_rate = 16'd256;
    queue_item(it);
    it.target_x = 32'sh0000_8000; it.damping_rate = 16'd4;
    queue_item(it);
    it.pos_now_x = 0; it.target_x = 32'sh0050_0000; it.damping_rate = 16'd1;
    for (int j = 0; j < 4; j++) queue_item(it);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < 3; i++) begin
      trail_pos[i] = near_coord();
      trail_tgt[i] = near_coord();
    end
    for (int j = 0; j < n; j++) queue_item(make_item());
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_positions.size() == 0) begin
        $display("%0t: unexpected item %h", $time, out_data);
        mismatches++;
      end else begin
        e = expected_positions.pop_front();
        if (e.new_x !== out_data.new_x) begin
          $display("%0t: new_x expected %h actual %h", $time, e.new_x, out_data.new_x);
          mismatches++;
        end
        if (e.new_y !== out_data.new_y) begin
          $display("%0t: new_y expected %h actual %h", $time, e.new_y, out_data.new_y);
          mismatches++;
        end
        if (e.new_z !== out_data.new_z) begin
          $display("%0t: new_z expected %h actual %h", $time, e.new_z, out_data.new_z);
          mismatches++;
        end
        if (e.snapped !== out_data.snapped) begin
          $display("%0t: snapped expected %b actual %b", $time, e.snapped, out_data.snapped);
          mismatches++;
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= 800;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && $urandom_range(99) < 22;
    end
  end

  initial begin
    logic [30:0] limits[5];
    velocity_q[0] = 0; velocity_q[1] = 0; velocity_q[2] = 0;
    speed_limit = 655360;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    random_phase(200);
    drain();
    limits[0] = 31'd0;
    limits[1] = 31'h7FFF_FFFF;
    limits[2] = 31'd196608;
    limits[3] = 31'($urandom());
    limits[4] = 31'd1;
    for (int ph = 0; ph < 5; ph++) begin
      write_max_speed(limits[ph]);
      calm = (ph == 2);
      if (ph == 1) hold_req++;
      random_phase(ph == 4 ? 100 : 180);
      drain();
    end
    calm = 1'b0;
    write_max_speed(31'd655360);
    random_phase(60);
    drain();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
